/* src/rde_pkg.sv */
// Shared types, constants and the control store for the radix digit emitter.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package rde_pkg;

  // Longest symbol run for one value; fraction digits are cut to fit.
  localparam int MAX_RESULTS = 50;
  // Dividend bits retired per divide step.
  localparam int CHUNK_BITS = 8;
  localparam int PC_BITS = 4;

  // Register indexes on the APB port (selected by paddr[2]).
  localparam logic REG_RADIX       = 1'b0;
  localparam logic REG_FRAC_DIGITS = 1'b1;

  localparam logic [4:0] RADIX_RESET       = 5'd10;
  localparam logic [4:0] FRAC_DIGITS_RESET = 5'd3;
  localparam logic [4:0] RADIX_MIN         = 5'd2;
  localparam logic [4:0] RADIX_MAX         = 5'd16;
  localparam logic [4:0] FRAC_DIGITS_MAX   = 5'd16;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_MINUS = 2'd1,
    KIND_POINT = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EMIT_MINUS,
    OP_DIV_CHUNK,
    OP_PUSH,
    OP_SET_FMAX,
    OP_EMIT_STACK,
    OP_EMIT_POINT,
    OP_EMIT_FRAC,
    OP_EMIT_EMPTY
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_VALUE_ZERO,
    C_NOT_NEG,
    C_QUO_ZERO,
    C_CHUNK_MORE,
    C_CNT_ZERO,
    C_FRAC_ZERO,
    C_FMAX_ZERO,
    C_FRAC_MORE
  } cond_t;

  typedef logic [PC_BITS-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // Program labels
  localparam pc_t PC_LOAD      = 4'd0;
  localparam pc_t PC_CHK_ZERO  = 4'd1;
  localparam pc_t PC_CHK_SIGN  = 4'd2;
  localparam pc_t PC_MINUS     = 4'd3;
  localparam pc_t PC_INT_TOP   = 4'd4;
  localparam pc_t PC_DIV       = 4'd5;
  localparam pc_t PC_PUSH      = 4'd6;
  localparam pc_t PC_SET_FMAX  = 4'd7;
  localparam pc_t PC_POP_TOP   = 4'd8;
  localparam pc_t PC_POP_EMIT  = 4'd9;
  localparam pc_t PC_FRAC_CHK  = 4'd10;
  localparam pc_t PC_POINT     = 4'd11;
  localparam pc_t PC_FRAC      = 4'd12;
  localparam pc_t PC_DONE      = 4'd13;
  localparam pc_t PC_EMPTY     = 4'd14;

  // Control store: a taken condition jumps to target, else fall through.
  function automatic ucode_t ucode_rom(input pc_t pc);
    case (pc)
      PC_LOAD:     ucode_rom = '{op: OP_LOAD,       cond: C_NEXT,       target: PC_LOAD};
      PC_CHK_ZERO: ucode_rom = '{op: OP_NOP,        cond: C_VALUE_ZERO, target: PC_EMPTY};
      PC_CHK_SIGN: ucode_rom = '{op: OP_NOP,        cond: C_NOT_NEG,    target: PC_INT_TOP};
      PC_MINUS:    ucode_rom = '{op: OP_EMIT_MINUS, cond: C_QUO_ZERO,   target: PC_LOAD};
      PC_INT_TOP:  ucode_rom = '{op: OP_NOP,        cond: C_QUO_ZERO,   target: PC_SET_FMAX};
      PC_DIV:      ucode_rom = '{op: OP_DIV_CHUNK,  cond: C_CHUNK_MORE, target: PC_DIV};
      PC_PUSH:     ucode_rom = '{op: OP_PUSH,       cond: C_ALWAYS,     target: PC_INT_TOP};
      PC_SET_FMAX: ucode_rom = '{op: OP_SET_FMAX,   cond: C_NEXT,       target: PC_LOAD};
      PC_POP_TOP:  ucode_rom = '{op: OP_NOP,        cond: C_CNT_ZERO,   target: PC_FRAC_CHK};
      PC_POP_EMIT: ucode_rom = '{op: OP_EMIT_STACK, cond: C_ALWAYS,     target: PC_POP_TOP};
      PC_FRAC_CHK: ucode_rom = '{op: OP_NOP,        cond: C_FRAC_ZERO,  target: PC_LOAD};
      PC_POINT:    ucode_rom = '{op: OP_EMIT_POINT, cond: C_FMAX_ZERO,  target: PC_LOAD};
      PC_FRAC:     ucode_rom = '{op: OP_EMIT_FRAC,  cond: C_FRAC_MORE,  target: PC_FRAC};
      PC_DONE:     ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_LOAD};
      PC_EMPTY:    ucode_rom = '{op: OP_EMIT_EMPTY, cond: C_ALWAYS,     target: PC_LOAD};
      default:     ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_LOAD};
    endcase
  endfunction

endpackage

/* src/rde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the integer digit stack.
`timescale 1ns / 1ps

module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/radix_digit_emitter_core.sv */
// Radix digit emitter core: fixed-point to base-radix symbol stream, APB config.
// Depends on rde_pkg (control store, types) and rde_ram (digit stack).
`timescale 1ns / 1ps

// Converts one signed Q(INT_BITS).(FRAC_BITS) value per request into a run of
// symbols: an optional minus sign, the integer digits most significant first
// (none for a zero integer part), and for a positive value with a nonzero
// fraction a radix point followed by up to frac_digits fraction digits,
// stopping once the remainder is zero. A zero value emits a single empty
// marker. The last flag marks the final symbol of each run. Control is a
// microprogram in rde_pkg::ucode_rom stepping a plain datapath: a shared
// divider retires CHUNK_BITS dividend bits per cycle, digits are pushed onto a
// RAM stack and popped back in order, and one fraction digit comes from one
// multiply by the radix per cycle while the output slot is free. Each integer
// digit takes DIV_STEPS = ceil(INT_BITS/8) divide steps, a loop test and a
// push, and later a pop through the registered RAM read. One value is in work
// at a time; the output register lets the next symbol be computed while the
// previous one waits.
// Registers: radix at 0x0 (values below 2 act as 2, above 16 as 16) and
// frac_digits at 0x4 (above 16 acts as 16); write them only while idle.

module radix_digit_emitter_core #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] value,
  input  logic                              in_valid,
  output logic                              in_ready,
  output logic [1:0]                        symbol_kind,
  output logic [3:0]                        digit,
  output logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int VAL_BITS  = INT_BITS + FRAC_BITS;
  localparam int DIV_STEPS = (INT_BITS + rde_pkg::CHUNK_BITS - 1) / rde_pkg::CHUNK_BITS;
  localparam int DIV_W     = DIV_STEPS * rde_pkg::CHUNK_BITS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CNT_W     = $clog2(INT_BITS + 1);
  localparam int AW        = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;
  localparam int PROD_W    = FRAC_BITS + 5;

  // Config registers
  logic [4:0] radix_reg;
  logic [4:0] frac_digits_reg;

  // Sequencer and datapath registers
  rde_pkg::pc_t         pc;
  rde_pkg::pc_t         pc_next;
  logic [DIV_W-1:0]     quo;
  logic [3:0]           rem;
  logic [FRAC_BITS-1:0] frac;
  logic                 neg;
  logic [4:0]           r;
  logic [4:0]           fmax;
  logic [4:0]           fcnt;
  logic [STEP_W-1:0]    chunk;
  logic [CNT_W-1:0]     cnt;

  // Output register
  logic                 out_valid_r;
  rde_pkg::kind_t       kind_r;
  logic [3:0]           digit_r;
  logic                 last_r;

  rde_pkg::ucode_t      uw;
  logic                 emit_op;
  logic                 out_free;
  logic                 stall;
  logic                 cond_true;
  logic                 cfg_write;

  logic [VAL_BITS-1:0]  raw;
  logic [VAL_BITS-1:0]  mag;
  logic [4:0]           r_in;
  logic [4:0]           fmax_in;

  logic [DIV_W-1:0]     div_quo;
  logic [3:0]           div_rem;
  logic [PROD_W-1:0]    prod;
  logic [3:0]           prod_digit;
  logic [FRAC_BITS-1:0] prod_frac;
  logic [4:0]           fcnt_inc;
  logic                 frac_done;
  logic [6:0]           limit;
  logic [CNT_W-1:0]     cnt_dec;

  logic                 ram_we;
  logic [3:0]           ram_rdata;

  // APB: always ready, registers addressed by paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      rde_pkg::REG_RADIX:       prdata = 32'(radix_reg);
      rde_pkg::REG_FRAC_DIGITS: prdata = 32'(frac_digits_reg);
      default:                  prdata = '0;
    endcase
  end

  // Fetch the current control word; hold off requests while in reset
  assign uw       = rde_pkg::ucode_rom(pc);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (uw.op == rde_pkg::OP_LOAD) && !rst;

  always_comb begin
    emit_op = uw.op inside {rde_pkg::OP_EMIT_MINUS, rde_pkg::OP_EMIT_STACK,
                            rde_pkg::OP_EMIT_POINT, rde_pkg::OP_EMIT_FRAC,
                            rde_pkg::OP_EMIT_EMPTY};
    // Hold the step while waiting for a request or for the output slot
    stall = (emit_op && !out_free) || ((uw.op == rde_pkg::OP_LOAD) && !in_valid);
  end

  // Load-time operand preparation: magnitude and clamped settings
  assign raw     = VAL_BITS'(value);
  assign mag     = raw[VAL_BITS-1] ? (~raw + VAL_BITS'(1)) : raw;
  assign r_in    = (radix_reg < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN :
                   (radix_reg > rde_pkg::RADIX_MAX) ? rde_pkg::RADIX_MAX : radix_reg;
  assign fmax_in = (frac_digits_reg > rde_pkg::FRAC_DIGITS_MAX) ?
                   rde_pkg::FRAC_DIGITS_MAX : frac_digits_reg;

  // Divider step: restoring division, CHUNK_BITS quotient bits per cycle.
  // Remainder stays below the radix, so five bits cover the trial value.
  always_comb begin
    logic [4:0]       t;
    logic [DIV_W-1:0] q;
    t = {1'b0, rem};
    q = quo;
    for (int j = 0; j < rde_pkg::CHUNK_BITS; j++) begin
      t = {t[3:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= r) begin
        t    = t - r;
        q[0] = 1'b1;
      end
    end
    div_quo = q;
    div_rem = t[3:0];
  end

  // Fraction digit: integer part of remainder times radix
  assign prod       = PROD_W'(frac) * PROD_W'(r);
  assign prod_digit = prod[FRAC_BITS+3:FRAC_BITS];
  assign prod_frac  = prod[FRAC_BITS-1:0];
  assign fcnt_inc   = fcnt + 5'd1;
  assign frac_done  = (fcnt_inc == fmax) || (prod_frac == '0);

  // Room left for fraction digits after the integer digits and the point
  assign limit   = 7'(rde_pkg::MAX_RESULTS - 1) - 7'(cnt);
  assign cnt_dec = cnt - CNT_W'(1);

  // Branch conditions, evaluated on the registered state
  always_comb begin
    case (uw.cond)
      rde_pkg::C_NEXT:       cond_true = 1'b0;
      rde_pkg::C_ALWAYS:     cond_true = 1'b1;
      rde_pkg::C_VALUE_ZERO: cond_true = (quo == '0) && (frac == '0) && !neg;
      rde_pkg::C_NOT_NEG:    cond_true = !neg;
      rde_pkg::C_QUO_ZERO:   cond_true = (quo == '0);
      rde_pkg::C_CHUNK_MORE: cond_true = (chunk != STEP_W'(DIV_STEPS - 1));
      rde_pkg::C_CNT_ZERO:   cond_true = (cnt == '0);
      rde_pkg::C_FRAC_ZERO:  cond_true = (frac == '0);
      rde_pkg::C_FMAX_ZERO:  cond_true = (fmax == '0);
      rde_pkg::C_FRAC_MORE:  cond_true = !frac_done;
      default:               cond_true = 1'b0;
    endcase
  end

  assign pc_next = stall ? pc : (cond_true ? uw.target : pc + rde_pkg::pc_t'(1));

  // Integer digit stack, least significant digit pushed first
  assign ram_we = !stall && (uw.op == rde_pkg::OP_PUSH);

  rde_ram #(
    .WIDTH (4),
    .DEPTH (INT_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (rem),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= rde_pkg::PC_LOAD;
      radix_reg       <= rde_pkg::RADIX_RESET;
      frac_digits_reg <= rde_pkg::FRAC_DIGITS_RESET;
      out_valid_r     <= 1'b0;
      cnt             <= '0;
      chunk           <= '0;
      fcnt            <= '0;
    end else begin
      pc <= pc_next;

      if (cfg_write) begin
        case (paddr[2])
          rde_pkg::REG_RADIX:       radix_reg       <= pwdata[4:0];
          rde_pkg::REG_FRAC_DIGITS: frac_digits_reg <= pwdata[4:0];
          default: ;
        endcase
      end

      // Drop the output once taken, unless an emit below refills it
      if (out_valid_r && out_ready && (stall || !emit_op)) begin
        out_valid_r <= 1'b0;
      end

      if (!stall) begin
        case (uw.op)
          rde_pkg::OP_LOAD: begin
            quo   <= DIV_W'(mag[VAL_BITS-1:FRAC_BITS]);
            frac  <= raw[VAL_BITS-1] ? '0 : mag[FRAC_BITS-1:0];
            neg   <= raw[VAL_BITS-1];
            r     <= r_in;
            fmax  <= fmax_in;
            rem   <= '0;
            cnt   <= '0;
            chunk <= '0;
          end
          rde_pkg::OP_DIV_CHUNK: begin
            quo   <= div_quo;
            rem   <= div_rem;
            chunk <= (chunk == STEP_W'(DIV_STEPS - 1)) ? '0 : chunk + STEP_W'(1);
          end
          rde_pkg::OP_PUSH: begin
            cnt <= cnt + CNT_W'(1);
            rem <= '0;
          end
          rde_pkg::OP_SET_FMAX: begin
            fmax <= ({2'b00, fmax} > limit) ? limit[4:0] : fmax;
            fcnt <= '0;
          end
          rde_pkg::OP_EMIT_MINUS: begin
            out_valid_r <= 1'b1;
            kind_r      <= rde_pkg::KIND_MINUS;
            digit_r     <= 4'd0;
            last_r      <= (quo == '0);
          end
          rde_pkg::OP_EMIT_STACK: begin
            out_valid_r <= 1'b1;
            kind_r      <= rde_pkg::KIND_DIGIT;
            digit_r     <= ram_rdata;
            last_r      <= (cnt == CNT_W'(1)) && (frac == '0);
            cnt         <= cnt_dec;
          end
          rde_pkg::OP_EMIT_POINT: begin
            out_valid_r <= 1'b1;
            kind_r      <= rde_pkg::KIND_POINT;
            digit_r     <= 4'd0;
            last_r      <= (fmax == '0);
          end
          rde_pkg::OP_EMIT_FRAC: begin
            out_valid_r <= 1'b1;
            kind_r      <= rde_pkg::KIND_DIGIT;
            digit_r     <= prod_digit;
            last_r      <= frac_done;
            frac        <= prod_frac;
            fcnt        <= fcnt_inc;
          end
          rde_pkg::OP_EMIT_EMPTY: begin
            out_valid_r <= 1'b1;
            kind_r      <= rde_pkg::KIND_EMPTY;
            digit_r     <= 4'd0;
            last_r      <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign symbol_kind = kind_r;
  assign digit       = digit_r;
  assign last        = last_r;

endmodule

/* src/rde_checker.sv */
// Port-level assertions for the radix digit emitter core, bound to the top.
// Depends on rde_pkg for the symbol kind codes.
`timescale 1ns / 1ps

module rde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] symbol_kind,
  input logic [3:0] digit,
  input logic       last,
  input logic       out_valid,
  input logic       out_ready
);

  // A stalled symbol holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol_kind) && $stable(digit)
      && $stable(last))
    else $error("output symbol changed while stalled");

  // Only digit symbols carry a digit value
  a_digit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (symbol_kind != rde_pkg::KIND_DIGIT) |-> (digit == 4'd0))
    else $error("non-digit symbol carries a digit value");

  // The empty marker is a run of its own
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (symbol_kind == rde_pkg::KIND_EMPTY) |-> last)
    else $error("empty marker not flagged last");

  // One value in work at a time: ready drops after an accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a value is in work");

endmodule

bind radix_digit_emitter_core rde_checker u_rde_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .symbol_kind (symbol_kind),
  .digit       (digit),
  .last        (last),
  .out_valid   (out_valid),
  .out_ready   (out_ready)
);

/* sim/rde_symbol_checker.sv */
`timescale 1ns / 1ps
// Symbol checker for radix_digit_emitter_core: follows the APB register writes,
// spells each accepted value into its symbol run and compares the output stream.
// Depends on rde_pkg for the symbol kinds, register indexes and limits.

module rde_symbol_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [47:0] value,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  symbol_kind,
  input  logic [3:0]  digit,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          symbols_owed,
  output int          mismatch_count
);

  typedef struct packed {
    rde_pkg::kind_t kind;
    logic [3:0]     digit;
    logic           last;
  } symbol_t;

  symbol_t    pending_symbols[$];
  logic [4:0] radix_reg;
  logic [4:0] frac_digits_reg;
  int         mismatches = 0;

  assign mismatch_count = mismatches;

  // Spell one Q31.16 value in the current base and queue its symbols.
  function automatic void spell_value(input logic [47:0] raw);
    symbol_t    run[$];
    symbol_t    sym;
    logic [3:0] int_digits[$];
    logic [47:0] mag;
    logic [31:0] quo;
    logic [31:0] base;
    logic [31:0] prod;
    logic [15:0] rem;
    int          fmax;
    base = 32'((radix_reg < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN :
               ((radix_reg > rde_pkg::RADIX_MAX) ? rde_pkg::RADIX_MAX : radix_reg));
    fmax = int'((frac_digits_reg > rde_pkg::FRAC_DIGITS_MAX) ?
                rde_pkg::FRAC_DIGITS_MAX : frac_digits_reg);
    mag  = raw[47] ? -raw : raw;
    quo  = mag[47:16];
    rem  = raw[47] ? 16'd0 : mag[15:0];
    if (raw[47])
      run.push_back('{kind: rde_pkg::KIND_MINUS, digit: 4'd0, last: 1'b0});
    while (quo != 0) begin
      int_digits.push_front(4'(quo % base));
      quo = quo / base;
    end
    foreach (int_digits[i])
      run.push_back('{kind: rde_pkg::KIND_DIGIT, digit: int_digits[i], last: 1'b0});
    if (rem != 0) begin
      run.push_back('{kind: rde_pkg::KIND_POINT, digit: 4'd0, last: 1'b0});
      if (rde_pkg::MAX_RESULTS - run.size() < fmax)
        fmax = rde_pkg::MAX_RESULTS - run.size();
      for (int k = 0; k < fmax && rem != 0; k++) begin
        prod = rem * base;
        run.push_back('{kind: rde_pkg::KIND_DIGIT, digit: prod[19:16], last: 1'b0});
        rem = prod[15:0];
      end
    end
    if (run.size() == 0)
      run.push_back('{kind: rde_pkg::KIND_EMPTY, digit: 4'd0, last: 1'b0});
    foreach (run[i]) begin
      sym = run[i];
      sym.last = (i == run.size() - 1);
      pending_symbols.push_back(sym);
    end
  endfunction

  always @(posedge clk) begin
    symbol_t want;
    if (rst) begin
      radix_reg <= rde_pkg::RADIX_RESET;
      frac_digits_reg <= rde_pkg::FRAC_DIGITS_RESET;
      pending_symbols.delete();
      symbols_owed <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == rde_pkg::REG_FRAC_DIGITS)
          frac_digits_reg <= pwdata[4:0];
        else
          radix_reg <= pwdata[4:0];
      end
      if (in_valid && in_ready)
        spell_value(value);
      if (out_valid && out_ready) begin
        if (pending_symbols.size() == 0) begin
          $display("%0t: symbol with none expected: kind %0d digit %0d last %0d",
                   $time, symbol_kind, digit, last);
          mismatches++;
        end else begin
          want = pending_symbols.pop_front();
          if (symbol_kind !== want.kind) begin
            $display("%0t: symbol_kind expected %0d, got %0d", $time, want.kind, symbol_kind);
            mismatches++;
          end
          if (digit !== want.digit) begin
            $display("%0t: digit expected %0d, got %0d", $time, want.digit, digit);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0d, got %0d", $time, want.last, last);
            mismatches++;
          end
        end
      end
      symbols_owed <= pending_symbols.size();
    end
  end

endmodule

/* sim/radix_digit_emitter_core_test.sv */
`timescale 1ns / 1ps
// Top of the radix_digit_emitter_core test: clock, reset, APB writes and value
// requests under several idling patterns. Depends on rde_pkg and rde_symbol_checker.

module radix_digit_emitter_core_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [47:0] value = '0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_ready;
  logic [1:0]  symbol_kind;
  logic [3:0]  digit;
  logic        last;
  logic        out_valid;
  logic [31:0] prdata;
  logic        pready;

  int symbols_owed;
  int mismatch_count;

  // Percent of cycles the request side holds back and the symbol side stalls.
  int idle_pct = 0;
  int stall_pct = 0;

  // Directed values, run at the reset settings (radix 10, three fraction digits).
  localparam logic [47:0] DIRECTED [15] = '{
    48'h0000_0000_0000,  // zero: lone empty marker
    48'h7FFF_FFFF_FFFF,  // largest positive, every fraction bit set
    48'h8000_0000_0000,  // most negative: magnitude needs bit 31 of the integer
    48'hFFFF_FFFF_FFFF,  // one lsb below zero: minus sign only
    48'h0000_0000_0001,  // smallest fraction, never terminates early
    48'h0000_0001_0000,  // 1.0: no radix point
    48'hFFFF_FFFF_8000,  // -0.5: negative with zero integer part
    48'h0000_0000_8000,  // 0.5: remainder hits zero after one digit
    48'h0000_0000_FFFF,  // all fraction bits
    48'h0000_007B_4000,  // 123.25
    48'hFFFF_FF84_C000,  // -123.25: fraction dropped
    48'h0000_0009_0000,  // single digit
    48'h0000_000A_0000,  // one full radix
    48'hFFFF_FFFF_0000,  // -1.0
    48'h7FFF_FFFF_0000   // largest integer, no fraction
  };

  // One row per random phase: register settings, then request and symbol idling.
  // The settings walk the clamps: radix below 2 and above 16, digit limits 0 and above 16.
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 21;
  localparam logic [4:0] RADIX_PLAN [PHASES] = '{5'd2, 5'd16, 5'd0, 5'd31,
                                                 5'd10, 5'd1, 5'd7, 5'd17};
  localparam logic [4:0] FRAC_PLAN [PHASES]  = '{5'd16, 5'd0, 5'd31, 5'd17,
                                                 5'd5, 5'd3, 5'd16, 5'd1};
  localparam int IDLE_PLAN [PHASES]  = '{0, 67, 0, 17, 0, 67, 0, 17};
  localparam int STALL_PLAN [PHASES] = '{0, 0, 67, 17, 0, 0, 67, 17};

  radix_digit_emitter_core uut (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol_kind(symbol_kind),
    .digit      (digit),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  rde_symbol_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .symbol_kind   (symbol_kind),
    .digit         (digit),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .symbols_owed  (symbols_owed),
    .mismatch_count(mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the symbol side at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // APB write: setup phase, then access until pready, then the bus goes idle.
  // Fill the unused upper data bits with noise; only the low five bits may
  // land in the register.
  task automatic write_reg(input logic reg_sel, input logic [4:0] field);
    logic [31:0] noise;
    noise = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {noise[31:5], field};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one value request, after a random idle gap; keep valid high across
  // back-to-back requests instead of dropping it in between.
  task automatic send_value(input logic [47:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every queued symbol has come out and the core
  // takes requests again; registers are only touched after this.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (symbols_owed != 0 || !in_ready);
  endtask

  // Mix of value shapes: raw 48-bit patterns, small and huge integer parts,
  // pure fractions, fractions that terminate, and the longest runs.
  function automatic logic [47:0] random_value();
    logic [63:0] wide;
    logic [31:0] int_part;
    logic [15:0] frac_part;
    logic [47:0] v;
    wide = {$urandom, $urandom};
    int_part = wide[31:0] >> $urandom_range(31);
    frac_part = 16'($urandom);
    case ($urandom_range(9))
      0, 1: return wide[47:0];
      2, 3: int_part = $urandom_range(999);
      4:    ;
      5:    int_part = '0;
      6: begin
        int_part = $urandom_range(99);
        frac_part = frac_part << $urandom_range(15);
      end
      7: begin
        // longest positive run in radix 2: 31 digits, point, 16 fraction digits
        int_part = 32'h7FFF_FFFF;
        frac_part = 16'h0001;
      end
      8:    int_part = 32'hFFFF_FFFF;
      default: begin
        int_part = '0;
        frac_part = 16'($urandom_range(1));
      end
    endcase
    v = {int_part, frac_part};
    if ($urandom_range(2) == 0)
      v = -v;
    return v;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed values at the reset settings, no idling on either side.
    foreach (DIRECTED[i])
      send_value(DIRECTED[i]);
    settle();

    // Random phases: reprogram both registers while idle, then stream values.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(rde_pkg::REG_RADIX, RADIX_PLAN[p]);
      write_reg(rde_pkg::REG_FRAC_DIGITS, FRAC_PLAN[p]);
      idle_pct = IDLE_PLAN[p];
      stall_pct = STALL_PLAN[p];
      repeat (PHASE_ITEMS)
        send_value(random_value());
      settle();
    end

    // Let a stray trailing symbol show up before the verdict.
    stall_pct = 0;
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && symbols_owed == 0)
      $display("** radix_digit_emitter_core: PASSED **");
    else
      $display("** radix_digit_emitter_core: FAILED **");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("** radix_digit_emitter_core: FAILED **");
    $finish;
  end

endmodule
